FILE: sv/mlpc_pkg.sv
`default_nettype none
package mlpc_pkg;

    // Table selector codes
    localparam logic [2:0] SEL_L1W = 3'd0;
    localparam logic [2:0] SEL_L1B = 3'd1;
    localparam logic [2:0] SEL_L2W = 3'd2;
    localparam logic [2:0] SEL_L2B = 3'd3;
    localparam logic [2:0] SEL_EXP = 3'd4;
    localparam logic [2:0] SEL_RCP = 3'd5;

    // Request kinds
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L1_BIAS,
        ST_L1_MAC,
        ST_L1_WAIT,
        ST_L1_DONE,
        ST_L2_BIAS,
        ST_L2_MAC,
        ST_L2_WAIT,
        ST_L2_DONE,
        ST_MAX,
        ST_EXP_LG,
        ST_EXP,
        ST_EXP_ACC,
        ST_RCP,
        ST_RCP_WAIT,
        ST_OUT_RD,
        ST_OUT_MUL,
        ST_OUT_HOLD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic       l1_bias;   // load acc from layer-1 bias (read issued)
        logic       l1_mac;    // accumulate layer-1 product
        logic       l1_store;  // ReLU and write hidden entry
        logic       l2_bias;
        logic       l2_mac;
        logic       l2_store;  // write logit entry
        logic       max_step;  // argmax compare
        logic       exp_lg;    // read logit of softmax class
        logic       exp_rd;    // issue exp table read
        logic       exp_acc;   // store exp entry, add to sum
        logic       rcp_rd;    // issue reciprocal read
        logic       rcp_load;  // latch reciprocal
        logic       out_rd;    // read exp/logit of output class
        logic       out_mul;   // form probability, load output register
        logic       clr;       // clear counters for next phase
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic i_last;  // inner counter at its last value
        logic o_last;  // outer counter at its last value
        logic out_taken;
    } stat_t;

    // Rounded Q16.16 product
    function automatic logic [31:0] fx_mul(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
        logic signed [63:0] p;
        logic [63:0] u;
        begin
            p = a * b;
            u = 64'(p) + 64'd32768;
            fx_mul = u[47:16];
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/mlp_q16_softmax_classifier.sv
`default_nettype none
// Two-layer Q16.16 classifier. Table words (tuser=0) load into on-chip memories;
// feature items (tuser=1) fill the feature store. A feature with tlast set
// starts an inference on a single multiply-accumulate unit: both layers, then
// argmax, table softmax and CLASS_COUNT results, one per class, last with tlast.
// No item is accepted while an inference runs, including while the result side
// holds tready low.
module mlp_q16_softmax_classifier #(
    parameter int INPUT_SIZE       = 64,
    parameter int HIDDEN_SIZE      = 16,
    parameter int CLASS_COUNT      = 10,
    parameter int TABLE_LAST_INDEX = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // table_select[2:0], word_index[12:3], word_value[44:13]
    input  wire logic        s_tuser,  // req_type
    input  wire logic        s_tlast,  // final_feature
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,  // class_index[3:0], logit_value[35:4],
                                       // probability[67:36], predicted_class[71:68]
    output logic             m_tlast   // last_of_run
);

    mlpc_pkg::cmd_t  cmd;
    mlpc_pkg::stat_t stat;
    logic            busy, acc, start;
    logic [3:0]      oc, op;
    logic [31:0]     ol, opr;

    assign s_tready = !busy;
    assign acc      = s_tvalid && s_tready;
    assign start    = acc && s_tuser == mlpc_pkg::REQ_SAMPLE && s_tlast;

    mlpc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mlpc_dp #(
        .INPUT_SIZE       (INPUT_SIZE),
        .HIDDEN_SIZE      (HIDDEN_SIZE),
        .CLASS_COUNT      (CLASS_COUNT),
        .TABLE_LAST_INDEX (TABLE_LAST_INDEX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (acc),
        .wr_sel    (s_tdata[2:0]),
        .wr_feat   (s_tuser),
        .wr_idx    (s_tdata[12:3]),
        .wr_val    (s_tdata[44:13]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_class (oc),
        .out_logit (ol),
        .out_prob  (opr),
        .out_pred  (op),
        .out_last  (m_tlast)
    );

    assign m_tdata = {op, opr, ol, oc};

endmodule
`default_nettype wire

FILE: sv/mlpc_ctrl.sv
`default_nettype none
module mlpc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire mlpc_pkg::stat_t stat,
    output mlpc_pkg::cmd_t       cmd,
    output logic                 busy
);

    mlpc_pkg::state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mlpc_pkg::ST_IDLE:     if (start) state_next = mlpc_pkg::ST_L1_BIAS;
            mlpc_pkg::ST_L1_BIAS:  state_next = mlpc_pkg::ST_L1_MAC;
            mlpc_pkg::ST_L1_MAC:   if (stat.i_last) state_next = mlpc_pkg::ST_L1_WAIT;
            mlpc_pkg::ST_L1_WAIT:  state_next = mlpc_pkg::ST_L1_DONE;
            mlpc_pkg::ST_L1_DONE:  state_next = stat.o_last ? mlpc_pkg::ST_L2_BIAS
                                                            : mlpc_pkg::ST_L1_BIAS;
            mlpc_pkg::ST_L2_BIAS:  state_next = mlpc_pkg::ST_L2_MAC;
            mlpc_pkg::ST_L2_MAC:   if (stat.i_last) state_next = mlpc_pkg::ST_L2_WAIT;
            mlpc_pkg::ST_L2_WAIT:  state_next = mlpc_pkg::ST_L2_DONE;
            mlpc_pkg::ST_L2_DONE:  state_next = stat.o_last ? mlpc_pkg::ST_MAX
                                                            : mlpc_pkg::ST_L2_BIAS;
            mlpc_pkg::ST_MAX:      if (stat.o_last) state_next = mlpc_pkg::ST_EXP_LG;
            mlpc_pkg::ST_EXP_LG:   state_next = mlpc_pkg::ST_EXP;
            mlpc_pkg::ST_EXP:      state_next = mlpc_pkg::ST_EXP_ACC;
            mlpc_pkg::ST_EXP_ACC:  state_next = stat.o_last ? mlpc_pkg::ST_RCP
                                                            : mlpc_pkg::ST_EXP_LG;
            mlpc_pkg::ST_RCP:      state_next = mlpc_pkg::ST_RCP_WAIT;
            mlpc_pkg::ST_RCP_WAIT: state_next = mlpc_pkg::ST_OUT_RD;
            mlpc_pkg::ST_OUT_RD:   state_next = mlpc_pkg::ST_OUT_MUL;
            mlpc_pkg::ST_OUT_MUL:  state_next = mlpc_pkg::ST_OUT_HOLD;
            mlpc_pkg::ST_OUT_HOLD:
                if (stat.out_taken)
                    state_next = stat.o_last ? mlpc_pkg::ST_IDLE : mlpc_pkg::ST_OUT_RD;
            default:               state_next = mlpc_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            mlpc_pkg::ST_IDLE:     cmd.clr = start;
            mlpc_pkg::ST_L1_BIAS:  cmd.l1_bias = 1'b1;
            mlpc_pkg::ST_L1_MAC:   cmd.l1_mac = 1'b1;
            mlpc_pkg::ST_L1_WAIT:  cmd.clr = 1'b0;  // product pipeline drains
            mlpc_pkg::ST_L1_DONE:  cmd.l1_store = 1'b1;
            mlpc_pkg::ST_L2_BIAS:  cmd.l2_bias = 1'b1;
            mlpc_pkg::ST_L2_MAC:   cmd.l2_mac = 1'b1;
            mlpc_pkg::ST_L2_WAIT:  cmd.clr = 1'b0;
            mlpc_pkg::ST_L2_DONE:  cmd.l2_store = 1'b1;
            mlpc_pkg::ST_MAX:      cmd.max_step = 1'b1;
            mlpc_pkg::ST_EXP_LG:   cmd.exp_lg = 1'b1;
            mlpc_pkg::ST_EXP:      cmd.exp_rd = 1'b1;
            mlpc_pkg::ST_EXP_ACC:  cmd.exp_acc = 1'b1;
            mlpc_pkg::ST_RCP:      cmd.rcp_rd = 1'b1;
            mlpc_pkg::ST_RCP_WAIT: cmd.rcp_load = 1'b1;
            mlpc_pkg::ST_OUT_RD:   cmd.out_rd = 1'b1;
            mlpc_pkg::ST_OUT_MUL:  cmd.out_mul = 1'b1;
            mlpc_pkg::ST_OUT_HOLD: cmd.clr = 1'b0;
            default:               cmd = '0;
        endcase
    end

    assign busy = (state_reg != mlpc_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mlpc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Start is only seen while idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == mlpc_pkg::ST_IDLE)
        else $error("start while busy");
    a_mac_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlpc_pkg::ST_L1_MAC && stat.i_last) |=>
            state_reg == mlpc_pkg::ST_L1_WAIT)
        else $error("layer-1 loop did not end");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlpc_pkg::ST_OUT_HOLD && !stat.out_taken) |=>
            state_reg == mlpc_pkg::ST_OUT_HOLD)
        else $error("result dropped");

endmodule
`default_nettype wire

FILE: sv/mlpc_dp.sv
`default_nettype none
module mlpc_dp #(
    parameter int INPUT_SIZE       = 64,
    parameter int HIDDEN_SIZE      = 16,
    parameter int CLASS_COUNT      = 10,
    parameter int TABLE_LAST_INDEX = 512
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // write port from input stream
    input  wire logic                wr_en,
    input  wire logic [2:0]          wr_sel,
    input  wire logic                wr_feat,
    input  wire logic [9:0]          wr_idx,
    input  wire logic [31:0]         wr_val,
    input  wire mlpc_pkg::cmd_t      cmd,
    output mlpc_pkg::stat_t          stat,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [3:0]               out_class,
    output logic [31:0]              out_logit,
    output logic [31:0]              out_prob,
    output logic [3:0]               out_pred,
    output logic                     out_last
);

    localparam int L1W_DEPTH = INPUT_SIZE * HIDDEN_SIZE;
    localparam int L2W_DEPTH = HIDDEN_SIZE * CLASS_COUNT;
    localparam int TBL_DEPTH = TABLE_LAST_INDEX + 1;
    localparam int IW  = (INPUT_SIZE > 1) ? $clog2(INPUT_SIZE) : 1;
    localparam int HW  = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
    localparam int CW  = $clog2(CLASS_COUNT);
    localparam int L1A = (L1W_DEPTH > 1) ? $clog2(L1W_DEPTH) : 1;
    localparam int L2A = $clog2(L2W_DEPTH);
    localparam int TA  = $clog2(TBL_DEPTH);
    localparam int CTW = (IW > HW) ? IW : HW;

    // Memories
    logic [31:0] l1w_mem [L1W_DEPTH];
    logic [31:0] l1b_mem [HIDDEN_SIZE];
    logic [31:0] l2w_mem [L2W_DEPTH];
    logic [31:0] l2b_mem [CLASS_COUNT];
    logic [31:0] exp_mem [TBL_DEPTH];
    logic [31:0] rcp_mem [TBL_DEPTH];
    logic [31:0] feat_mem [INPUT_SIZE];
    logic [31:0] hid_mem [HIDDEN_SIZE];
    logic [31:0] logit_mem [CLASS_COUNT];
    logic [31:0] es_mem [CLASS_COUNT];

    // Counters: inner (j or hidden i), outer (row or class)
    logic [CTW-1:0] in_reg;
    logic [HW+CW:0] out_cnt_reg;
    logic [L1A-1:0] l1a_reg;
    logic [L2A-1:0] l2a_reg;
    logic           l1_phase;

    logic [31:0] acc_reg, prod_reg;
    logic        prod_vld_reg, mac_vld_reg, bias_ld_reg;
    logic        max_vld_reg;
    logic [CW-1:0] max_idx_reg;
    logic [31:0] mx_reg, sum_reg, rcp_reg, es_rd_reg, lg_rd_reg;
    logic [31:0] w_rd_reg, x_rd_reg, b_rd_reg, t_rd_reg;
    logic [3:0]  best_reg;
    logic [CW-1:0] cls_reg;

    logic [31:0] ov_logit_reg, ov_prob_reg;
    logic [3:0]  ov_class_reg;
    logic        ov_last_reg, ov_valid_reg;

    // Table and feature writes
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_feat && wr_idx < 10'(INPUT_SIZE))
            feat_mem[wr_idx[IW-1:0]] <= wr_val;
        if (wr_en && !wr_feat)
        begin
            if (wr_sel == mlpc_pkg::SEL_L1W && 11'(wr_idx) < 11'(L1W_DEPTH))
                l1w_mem[wr_idx[L1A-1:0]] <= wr_val;
            if (wr_sel == mlpc_pkg::SEL_L2W && 11'(wr_idx) < 11'(L2W_DEPTH))
                l2w_mem[wr_idx[L2A-1:0]] <= wr_val;
            if (wr_sel == mlpc_pkg::SEL_EXP && 11'(wr_idx) < 11'(TBL_DEPTH))
                exp_mem[wr_idx[TA-1:0]] <= wr_val;
            if (wr_sel == mlpc_pkg::SEL_RCP && 11'(wr_idx) < 11'(TBL_DEPTH))
                rcp_mem[wr_idx[TA-1:0]] <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_feat && wr_sel == mlpc_pkg::SEL_L1B &&
            wr_idx < 10'(HIDDEN_SIZE))
            l1b_mem[wr_idx[HW-1:0]] <= wr_val;
        if (wr_en && !wr_feat && wr_sel == mlpc_pkg::SEL_L2B &&
            wr_idx < 10'(CLASS_COUNT))
            l2b_mem[wr_idx[CW-1:0]] <= wr_val;
    end

    // Index helpers
    logic [HW-1:0] row_hw;
    logic [CW-1:0] row_cw;
    logic          i_last_l1, i_last_l2;
    assign row_hw    = out_cnt_reg[HW-1:0];
    assign row_cw    = out_cnt_reg[CW-1:0];
    assign i_last_l1 = (in_reg == CTW'(INPUT_SIZE - 1));
    assign i_last_l2 = (in_reg == CTW'(HIDDEN_SIZE - 1));

    // Softmax index from exact difference
    logic signed [33:0] d_s;
    logic [31:0]        ex_ix;
    logic [TA-1:0]      ex_ix_t;
    always_comb
    begin
        d_s = 34'(signed'(lg_rd_reg)) - 34'(signed'(mx_reg));
        if (d_s < -34'sd524288)
            d_s = -34'sd524288;
        ex_ix = 32'((d_s + 34'sd524288) >>> 10);
        if (ex_ix > 32'(TABLE_LAST_INDEX))
            ex_ix = 32'(TABLE_LAST_INDEX);
        ex_ix_t = ex_ix[TA-1:0];
    end

    logic [31:0]   s_fix, s_ix;
    logic [TA-1:0] s_ix_t;
    always_comb
    begin
        s_fix = (signed'(sum_reg) <= 0) ? 32'd1 : sum_reg;
        s_ix  = s_fix >> 10;
        if (s_ix < 32'd1) s_ix = 32'd1;
        if (s_ix > 32'(TABLE_LAST_INDEX)) s_ix = 32'(TABLE_LAST_INDEX);
        s_ix_t = s_ix[TA-1:0];
    end

    // Memory reads (registered)
    always_ff @(posedge clk)
    begin
        w_rd_reg  <= l1_phase ? l1w_mem[l1a_reg] : l2w_mem[l2a_reg];
        x_rd_reg  <= l1_phase ? feat_mem[in_reg[IW-1:0]] : hid_mem[in_reg[HW-1:0]];
        b_rd_reg  <= l1_phase ? l1b_mem[row_hw] : l2b_mem[row_cw];
        lg_rd_reg <= logit_mem[(cmd.out_rd || cmd.exp_lg) ? cls_reg : row_cw];
        es_rd_reg <= es_mem[cls_reg];
        t_rd_reg  <= cmd.rcp_rd ? rcp_mem[s_ix_t] : exp_mem[ex_ix_t];
    end

    // Track phase and counters
    logic mac_any;
    assign mac_any = cmd.l1_mac | cmd.l2_mac;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg       <= '0;
            out_cnt_reg  <= '0;
            l1a_reg      <= '0;
            l2a_reg      <= '0;
            l1_phase     <= 1'b1;
            mac_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            bias_ld_reg  <= 1'b0;
            max_vld_reg  <= 1'b0;
            max_idx_reg  <= '0;
            cls_reg      <= '0;
            best_reg     <= '0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            mac_vld_reg  <= mac_any;
            prod_vld_reg <= mac_vld_reg;
            bias_ld_reg  <= cmd.l1_bias | cmd.l2_bias;
            max_vld_reg  <= cmd.max_step;
            max_idx_reg  <= row_cw;
            if (cmd.clr)
            begin
                in_reg      <= '0;
                out_cnt_reg <= '0;
                l1a_reg     <= '0;
                l2a_reg     <= '0;
                l1_phase    <= 1'b1;
                cls_reg     <= '0;
            end
            if (mac_any && !(cmd.l1_mac ? i_last_l1 : i_last_l2))
            begin
                in_reg <= in_reg + 1'b1;
                if (cmd.l1_mac) l1a_reg <= l1a_reg + 1'b1;
                else            l2a_reg <= l2a_reg + 1'b1;
            end
            if (mac_any && (cmd.l1_mac ? i_last_l1 : i_last_l2))
            begin
                in_reg <= '0;
                if (cmd.l1_mac) l1a_reg <= l1a_reg + 1'b1;
                else            l2a_reg <= l2a_reg + 1'b1;
            end
            // Store, argmax and exp-accumulate steps advance outer counter
            if (cmd.l1_store)
            begin
                if (stat.o_last)
                begin
                    out_cnt_reg <= '0;
                    l1_phase    <= 1'b0;
                end
                else
                    out_cnt_reg <= out_cnt_reg + 1'b1;
            end
            if (cmd.l2_store || cmd.max_step || cmd.exp_acc)
                out_cnt_reg <= stat.o_last ? '0 : out_cnt_reg + 1'b1;
            // Argmax compare in the cycle after the logit read
            if (max_vld_reg)
            begin
                if (max_idx_reg == '0 || signed'(lg_rd_reg) > signed'(mx_reg))
                begin
                    best_reg <= 4'(max_idx_reg);
                end
            end
            if (cmd.exp_acc)
                cls_reg <= stat.o_last ? '0 : cls_reg + 1'b1;
            if (cmd.out_mul)
                ov_valid_reg <= 1'b1;
            else if (ov_valid_reg && out_ready)
            begin
                ov_valid_reg <= 1'b0;
                cls_reg <= cls_reg + 1'b1;
            end
        end
    end

    // Datapath registers: MAC with one product stage after the read stage.
    // The running max follows the argmax compare on the registered logit.
    always_ff @(posedge clk)
    begin
        prod_reg <= mlpc_pkg::fx_mul(w_rd_reg, x_rd_reg);
        if (bias_ld_reg)
            acc_reg <= b_rd_reg;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + prod_reg;
        if (max_vld_reg &&
            (max_idx_reg == '0 || signed'(lg_rd_reg) > signed'(mx_reg)))
            mx_reg <= lg_rd_reg;
        if (cmd.exp_rd && cls_reg == '0)
            sum_reg <= '0;
        if (cmd.exp_acc)
        begin
            es_mem[cls_reg] <= t_rd_reg;
            sum_reg <= sum_reg + t_rd_reg;
        end
        if (cmd.rcp_load)
            rcp_reg <= t_rd_reg;
        if (cmd.out_mul)
        begin
            ov_prob_reg  <= mlpc_pkg::fx_mul(es_rd_reg, rcp_reg);
            ov_logit_reg <= lg_rd_reg;
            ov_class_reg <= 4'(cls_reg);
            ov_last_reg  <= (cls_reg == CW'(CLASS_COUNT - 1));
        end
    end

    // Stores of hidden and logit values; final accumulate lands in DONE state
    logic [31:0] acc_fin;
    assign acc_fin = prod_vld_reg ? acc_reg + prod_reg : acc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.l1_store)
            hid_mem[row_hw] <= acc_fin[31] ? 32'd0 : acc_fin;
        if (cmd.l2_store)
            logit_mem[row_cw] <= acc_fin;
    end

    assign stat.i_last    = cmd.l1_mac ? i_last_l1 : i_last_l2;
    assign stat.o_last    = (cmd.l1_store) ? (row_hw == HW'(HIDDEN_SIZE - 1)) :
                            (cmd.out_mul || ov_valid_reg) ?
                                (cls_reg == CW'(CLASS_COUNT - 1)) :
                            (cmd.exp_acc) ? (cls_reg == CW'(CLASS_COUNT - 1)) :
                            (row_cw == CW'(CLASS_COUNT - 1));
    assign stat.out_taken = ov_valid_reg && out_ready;

    assign out_valid = ov_valid_reg;
    assign out_class = ov_class_reg;
    assign out_logit = ov_logit_reg;
    assign out_prob  = ov_prob_reg;
    assign out_pred  = best_reg;
    assign out_last  = ov_last_reg;

    a_prob_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result lost");
    a_pred_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_pred < 4'(CLASS_COUNT))
        else $error("argmax out of range");
    a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_class < 4'(CLASS_COUNT))
        else $error("class out of range");

endmodule
`default_nettype wire
